[rtl/hte_pkg.sv]
// Shared types, character codes and helpers of the hex tape record encoder.
// No dependencies; imported by every file of the block but hte_ram.

package hte_pkg;

  // Fixed widths of the request fields and the configuration registers.
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned SUM_W  = 16;

  // Register indexes on the configuration port.
  localparam logic REG_START_ADDR = 1'b0;
  localparam logic REG_RECORD_LEN = 1'b1;

  localparam logic [ADDR_W-1:0] RESET_START_ADDR = 16'h0200;
  localparam logic [LEN_W-1:0]  RESET_RECORD_LEN = 5'd24;

  // Closed records held by the block at once: one being printed, one waiting.
  localparam logic [1:0] PENDING_MAX = 2'd2;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       record_end;
  } out_item_t;

  // One closed record, handed from the front end to the printer.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  sum;
    logic              bank;
  } rec_desc_t;

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'h0, v};
    end else begin
      c = 8'h37 + {4'h0, v};
    end
    return c;
  endfunction

endpackage

[rtl/hte_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module hte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hte_front.sv]
// Front end: takes data bytes, stores them in the record buffer, keeps the
// running sum and address, and closes records. Depends on hte_pkg.

module hte_front import hte_pkg::*; #(
  parameter int unsigned RECORD_BYTES = 24,
  localparam int unsigned CW = $clog2(RECORD_BYTES + 1),
  localparam int unsigned IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  input  logic [ADDR_W-1:0] cfg_start_i,
  input  logic [LEN_W-1:0]  cfg_len_i,
  input  logic              start_wr_i,
  input  logic [ADDR_W-1:0] start_wdata_i,
  output logic              ram_we_o,
  output logic [IW:0]       ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              push_o,
  output rec_desc_t         push_data_o,
  input  logic              rec_done_i
);

  localparam logic [LEN_W:0] RB_EXT = (LEN_W + 1)'(RECORD_BYTES);

  logic [CW-1:0]     fill_q, fill_d, fill_inc, eff_len;
  logic [SUM_W-1:0]  sum_q, sum_d, sum_new;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              mid_q, mid_d, bank_q, bank_d;
  logic [1:0]        pend_q, pend_d;
  logic              accept, close;

  always_comb begin
    if (cfg_len_i == '0) begin
      eff_len = CW'(1);
    end else if ({1'b0, cfg_len_i} > RB_EXT) begin
      eff_len = CW'(RECORD_BYTES);
    end else begin
      eff_len = CW'(cfg_len_i);
    end
  end

  assign in_ready_o = (pend_q != PENDING_MAX);
  assign accept     = in_valid_i && in_ready_o;
  assign fill_inc   = fill_q + 1'b1;
  assign sum_new    = sum_q + {8'h00, in_data_i.data_byte};
  // A lowered length closes the record as soon as the next byte lands.
  assign close      = (fill_inc >= eff_len) || in_data_i.final_byte;

  assign ram_we_o    = accept;
  assign ram_waddr_o = {bank_q, fill_q[IW-1:0]};
  assign ram_wdata_o = in_data_i.data_byte;

  assign push_o           = accept && close;
  assign push_data_o.len  = LEN_W'(fill_inc);
  assign push_data_o.addr = addr_q;
  assign push_data_o.sum  = sum_new;
  assign push_data_o.bank = bank_q;

  always_comb begin
    fill_d = fill_q;
    sum_d  = sum_q;
    addr_d = addr_q;
    mid_d  = mid_q;
    bank_d = bank_q;
    if (accept) begin
      if (close) begin
        fill_d = '0;
        sum_d  = '0;
        bank_d = ~bank_q;
        if (in_data_i.final_byte) begin
          addr_d = cfg_start_i;
          mid_d  = 1'b0;
        end else begin
          addr_d = addr_q + ADDR_W'(fill_inc);
          mid_d  = 1'b1;
        end
      end else begin
        fill_d = fill_inc;
        sum_d  = sum_new;
        mid_d  = 1'b1;
      end
    end else if (start_wr_i && !mid_q) begin
      addr_d = start_wdata_i;
    end
    pend_d = pend_q + {1'b0, push_o} - {1'b0, rec_done_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      addr_q <= RESET_START_ADDR;
      mid_q  <= 1'b0;
      bank_q <= 1'b0;
      pend_q <= '0;
    end else begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
      addr_q <= addr_d;
      mid_q  <= mid_d;
      bank_q <= bank_d;
      pend_q <= pend_d;
    end
  end

endmodule

[rtl/hte_queue.sv]
// Two-entry queue of closed records between the front end and the printer.
// Depends on hte_pkg.

module hte_queue import hte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rec_desc_t push_data_i,
  input  logic      pop_i,
  output rec_desc_t pop_data_o,
  output logic      empty_o,
  output logic      full_o
);

  rec_desc_t  entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign empty_o    = (count_q == 2'd0);
  assign full_o     = (count_q == 2'd2);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[rtl/hte_back.sv]
// Printer: turns a closed record into text, one character per cycle while
// not stalled, reading data bytes from the record buffer. Depends on hte_pkg.

module hte_back import hte_pkg::*; #(
  parameter int unsigned IW = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  rec_desc_t  pop_data_i,
  output logic       pop_o,
  output logic       ram_re_o,
  output logic [IW:0] ram_raddr_o,
  input  logic [7:0] ram_rdata_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  output logic       rec_done_o
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_HEAD,
    B_DHI,
    B_DLO,
    B_TAIL
  } back_state_e;

  localparam logic [2:0] HEAD_LAST = 3'd6;
  localparam logic [2:0] TAIL_LAST = 3'd5;

  back_state_e       state_q;
  logic [2:0]        cnt_q;
  logic [IW-1:0]     idx_q, idx_next;
  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SUM_W-1:0]  chk_q, chk_new;
  logic              bank_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              slot_free, fire, last_byte;
  logic [7:0]        len_byte, ch;

  assign slot_free = !out_valid_q || out_ready_i;
  assign fire      = (state_q != B_IDLE) && slot_free;
  assign pop_o     = (state_q == B_IDLE) && !empty_i;
  assign last_byte = ((LEN_W'(idx_q) + 1'b1) == len_q);
  assign len_byte  = {{(8 - LEN_W){1'b0}}, len_q};
  assign chk_new   = pop_data_i.sum + SUM_W'(pop_data_i.len)
                   + {8'h00, pop_data_i.addr[15:8]} + {8'h00, pop_data_i.addr[7:0]};

  // The read for a data byte goes out while the previous character is shown.
  assign idx_next    = (state_q == B_HEAD) ? '0 : idx_q + 1'b1;
  assign ram_re_o    = fire && (((state_q == B_HEAD) && (cnt_q == HEAD_LAST))
                               || ((state_q == B_DLO) && !last_byte));
  assign ram_raddr_o = {bank_q, idx_next};

  assign rec_done_o  = fire && (state_q == B_TAIL) && (cnt_q == TAIL_LAST);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ch = CH_SEMI;
    unique case (state_q)
      B_HEAD: begin
        case (cnt_q)
          3'd0:    ch = CH_SEMI;
          3'd1:    ch = hex_char(len_byte[7:4]);
          3'd2:    ch = hex_char(len_byte[3:0]);
          3'd3:    ch = hex_char(addr_q[15:12]);
          3'd4:    ch = hex_char(addr_q[11:8]);
          3'd5:    ch = hex_char(addr_q[7:4]);
          default: ch = hex_char(addr_q[3:0]);
        endcase
      end
      B_DHI:   ch = hex_char(ram_rdata_i[7:4]);
      B_DLO:   ch = hex_char(ram_rdata_i[3:0]);
      B_TAIL: begin
        case (cnt_q)
          3'd0:    ch = hex_char(chk_q[15:12]);
          3'd1:    ch = hex_char(chk_q[11:8]);
          3'd2:    ch = hex_char(chk_q[7:4]);
          3'd3:    ch = hex_char(chk_q[3:0]);
          3'd4:    ch = CH_CR;
          default: ch = CH_LF;
        endcase
      end
      default: ch = CH_SEMI;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      len_q       <= '0;
      addr_q      <= '0;
      chk_q       <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (fire) begin
        out_valid_q      <= 1'b1;
        out_q.out_char   <= ch;
        out_q.record_end <= rec_done_o;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            len_q   <= pop_data_i.len;
            addr_q  <= pop_data_i.addr;
            chk_q   <= chk_new;
            bank_q  <= pop_data_i.bank;
            cnt_q   <= '0;
            state_q <= B_HEAD;
          end
        end
        B_HEAD: begin
          if (fire) begin
            if (cnt_q == HEAD_LAST) begin
              idx_q   <= idx_next;
              state_q <= B_DHI;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        B_DHI: begin
          if (fire) begin
            state_q <= B_DLO;
          end
        end
        B_DLO: begin
          if (fire) begin
            if (last_byte) begin
              cnt_q   <= '0;
              state_q <= B_TAIL;
            end else begin
              idx_q   <= idx_next;
              state_q <= B_DHI;
            end
          end
        end
        B_TAIL: begin
          if (fire) begin
            if (cnt_q == TAIL_LAST) begin
              state_q <= B_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/hex_tape_record_encoder.sv]
// Top level of the hex tape record encoder: configuration registers, record
// buffer, front end, record queue and printer. Depends on hte_pkg, hte_ram,
// hte_front, hte_queue and hte_back.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-----------------------------
//   in       | input     | in_valid/in_ready | in_data_i  (in_item_t)
//   out      | output    | out_valid/ready   | out_data_o (out_item_t)
//   config   | input     | APB, pready tied  | start_address, record_length
//
// The front end takes one request per cycle. A record of n bytes prints as
// 2n+13 characters at one per cycle while the output is taken, after the
// printer fetches the record from the queue; the printer sets the rate.
// Requests stall while two closed records wait or print, since the buffer
// has two banks. The output register holds a character until it is taken.
// Reset clears all control state; no clearing pass runs.

module hex_tape_record_encoder import hte_pkg::*; #(
  parameter int unsigned RECORD_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int unsigned RAM_DEPTH = 2 * (1 << IW);

  logic [ADDR_W-1:0] start_addr_q;
  logic [LEN_W-1:0]  record_len_q;
  logic              cfg_wr, start_wr;

  logic              ram_we, ram_re;
  logic [IW:0]       ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              q_push, q_pop, q_empty, q_full, rec_done;
  rec_desc_t         q_in, q_out;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign start_wr = cfg_wr && (paddr[2] == REG_START_ADDR);

  always_comb begin
    unique case (paddr[2])
      REG_START_ADDR: prdata = {16'h0000, start_addr_q};
      REG_RECORD_LEN: prdata = {27'h0, record_len_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= RESET_START_ADDR;
      record_len_q <= RESET_RECORD_LEN;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_ADDR) begin
        start_addr_q <= pwdata[15:0];
      end else begin
        record_len_q <= pwdata[4:0];
      end
    end
  end

  hte_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hte_front #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .cfg_start_i   (start_addr_q),
    .cfg_len_i     (record_len_q),
    .start_wr_i    (start_wr),
    .start_wdata_i (pwdata[15:0]),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .push_o        (q_push),
    .push_data_o   (q_in),
    .rec_done_i    (rec_done)
  );

  hte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  hte_back #(
    .IW (IW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .pop_data_i  (q_out),
    .pop_o       (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .rec_done_o  (rec_done)
  );

  // A closed record never meets a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("record pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("record taken from an empty queue");

  // The record end flag only ever rides on a line feed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_end |-> out_data_o.out_char == CH_LF)
    else $error("record end flagged on a character other than LF");

  // A finished record frees a bank, so requests are taken again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_done && !q_push |=> in_ready_o)
    else $error("front end still stalled after a record finished");

endmodule
